// File: design/plid_pkg.sv
// ============================================================================
// plid_pkg
// Shared types and constants for the positional list insert/delete unit.
// ============================================================================
package plid_pkg;

    // Fixed field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 7;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    // Upper bound on the list length set by the length field
    localparam int LEN_MAX = 127;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FINISH,
        ST_DONE
    } t_state;

    // Decoded request: legality, number of memory reads, first read slot and
    // the slot addressed by the position (all in list-index terms)
    typedef struct packed {
        logic             legal;
        logic [CNT_W-1:0] moves;
        logic [POS_W-1:0] src;
        logic [POS_W-1:0] slot;
    } t_req_info;

endpackage

// File: design/plid_decode.sv
// ============================================================================
// plid_decode
// Checks a request against the current length and works out the memory pass
// that carries it out.
// ============================================================================
module plid_decode #(
    parameter int LIMIT = 64
) (
    input  plid_pkg::t_func                  i_func,
    input  logic [plid_pkg::POS_W-1:0]       i_position,
    input  logic [plid_pkg::CNT_W-1:0]       i_count,
    output plid_pkg::t_req_info              o_info
);

    localparam logic [plid_pkg::CNT_W-1:0] LimitW = plid_pkg::CNT_W'(LIMIT);

    logic                         w_pos_nz;
    logic [plid_pkg::CNT_W:0]     w_count_p1;
    logic [plid_pkg::POS_W-1:0]   w_slot;

    assign w_pos_nz   = (i_position != '0);
    assign w_count_p1 = {1'b0, i_count} + (plid_pkg::CNT_W+1)'(1);
    assign w_slot     = i_position - plid_pkg::POS_W'(1);

    // Legality and shift extent per request code
    always_comb begin
        o_info.legal = 1'b0;
        o_info.moves = '0;
        o_info.src   = '0;
        o_info.slot  = w_slot;
        unique case (i_func)
            plid_pkg::FUNC_INSERT: begin
                // entries count-1 down to slot move up by one
                o_info.legal = w_pos_nz && ({1'b0, i_position} <= w_count_p1)
                               && (i_count < LimitW);
                o_info.moves = i_count - w_slot;
                o_info.src   = i_count - plid_pkg::POS_W'(1);
            end
            plid_pkg::FUNC_DELETE: begin
                // entries position up to count-1 move down by one
                o_info.legal = w_pos_nz && (i_position <= i_count);
                o_info.moves = i_count - i_position;
                o_info.src   = i_position;
            end
            plid_pkg::FUNC_READ: begin
                o_info.legal = w_pos_nz && (i_position <= i_count);
                o_info.moves = plid_pkg::CNT_W'(1);
                o_info.src   = w_slot;
            end
            default: begin
                o_info.legal = 1'b0;
            end
        endcase
    end

endmodule

// File: design/positional_list_insert_delete_unit.sv
// ============================================================================
// positional_list_insert_delete_unit
// Ordered list of signed 32-bit values held in one synchronous memory,
// addressed by 1-based position, with insert, delete and read requests.
// ============================================================================
// Usage:
//   Request channel i_valid/o_ready carries i_func (0 insert, 1 delete,
//   2 read), i_position and i_value. Result channel o_valid/i_ready carries
//   o_status (0 ok, 1 error), o_length and o_read_value. One result per
//   request, in order.
//   A legal request runs a shift pass of M memory reads, where M
//   is the number of entries read: length - position + 1 for an insert,
//   length - position for a delete, one for a read; an error skips the pass.
//   The shift pass moves one entry per cycle through the single read port
//   and single write port of the entry memory, so that pass sets the rate;
//   the worst case is an insert at the head of a list one short of full.
//   One request is in flight at a time; o_ready is high while idle.
//   Reset (i_rst_n low, synchronous) empties the list; memory contents are
//   not cleared and need no clearing pass, as only written entries are read.
//   A result waiting on a stalled receiver does not block the next request;
//   that request completes its work and then holds until the result
//   register frees up.
// ============================================================================
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [plid_pkg::FUNC_W-1:0]       i_func,
    input  logic [plid_pkg::POS_W-1:0]        i_position,
    input  logic signed [plid_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_status,
    output logic [plid_pkg::CNT_W-1:0]        o_length,
    output logic signed [plid_pkg::DATA_W-1:0] o_read_value
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIMIT = (CAPACITY < plid_pkg::LEN_MAX) ? CAPACITY : plid_pkg::LEN_MAX;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    plid_pkg::t_state                 r_state, n_state;
    plid_pkg::t_func                  r_op, n_op;
    logic                             r_legal, n_legal;
    logic [plid_pkg::CNT_W-1:0]       r_left, n_left;
    logic [AW-1:0]                    r_src, n_src;
    logic [AW-1:0]                    r_dst, n_dst;
    logic [AW-1:0]                    r_slot, n_slot;
    logic                             r_pend, n_pend;
    logic [plid_pkg::DATA_W-1:0]      r_val, n_val;
    logic [plid_pkg::DATA_W-1:0]      r_rd, n_rd;
    logic [plid_pkg::CNT_W-1:0]       r_count, n_count;
    logic                             r_o_valid, n_o_valid;
    logic                             r_o_status, n_o_status;
    logic [plid_pkg::CNT_W-1:0]       r_o_length, n_o_length;
    logic [plid_pkg::DATA_W-1:0]      r_o_read_value, n_o_read_value;

    logic [plid_pkg::DATA_W-1:0]      r_mem [CAPACITY];
    logic [plid_pkg::DATA_W-1:0]      r_rdata;

    plid_pkg::t_req_info              w_info;
    logic                             w_accept;
    logic                             w_issue;
    logic                             w_load_out;
    logic                             w_we;
    logic [AW-1:0]                    w_waddr;
    logic [plid_pkg::DATA_W-1:0]      w_wdata;

    // ------------------------------------------------------------------
    // Request check
    // ------------------------------------------------------------------
    plid_decode #(
        .LIMIT (LIMIT)
    ) u_decode (
        .i_func     (plid_pkg::t_func'(i_func)),
        .i_position (i_position),
        .i_count    (r_count),
        .o_info     (w_info)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plid_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = w_info.legal ? plid_pkg::ST_SHIFT : plid_pkg::ST_DONE;
                end
            end
            plid_pkg::ST_SHIFT: begin
                // last read issued; its write-back lands this cycle
                if (r_left == '0) begin
                    n_state = plid_pkg::ST_FINISH;
                end
            end
            plid_pkg::ST_FINISH: begin
                n_state = plid_pkg::ST_DONE;
            end
            plid_pkg::ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_state = plid_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = plid_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_ready    = 1'b0;
        w_issue    = 1'b0;
        w_load_out = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_dst;
        w_wdata    = r_rdata;
        unique case (r_state)
            plid_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            plid_pkg::ST_SHIFT: begin
                w_issue = (r_left != '0);
                // moved entry written in the cycle after its read is issued
                w_we    = r_pend && (r_op != plid_pkg::FUNC_READ);
            end
            plid_pkg::ST_FINISH: begin
                // new value into the gap opened by the shift
                w_we    = (r_op == plid_pkg::FUNC_INSERT);
                w_waddr = r_slot;
                w_wdata = r_val;
            end
            plid_pkg::ST_DONE: begin
                w_load_out = !r_o_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_valid && o_ready;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        n_op           = r_op;
        n_legal        = r_legal;
        n_left         = r_left;
        n_src          = r_src;
        n_dst          = r_dst;
        n_slot         = r_slot;
        n_pend         = w_issue;
        n_val          = r_val;
        n_rd           = r_rd;
        n_count        = r_count;
        n_o_valid      = r_o_valid && !i_ready;
        n_o_status     = r_o_status;
        n_o_length     = r_o_length;
        n_o_read_value = r_o_read_value;

        // capture the request
        if (w_accept) begin
            n_op    = plid_pkg::t_func'(i_func);
            n_legal = w_info.legal;
            n_left  = w_info.moves;
            n_src   = AW'(w_info.src);
            n_slot  = AW'(w_info.slot);
            n_val   = i_value;
            n_rd    = '0;
        end

        // shift pass: step the read pointer, remember the write target
        if (w_issue) begin
            n_left = r_left - plid_pkg::CNT_W'(1);
            if (r_op == plid_pkg::FUNC_INSERT) begin
                n_src = r_src - AW'(1);
                n_dst = r_src + AW'(1);
            end else begin
                n_src = r_src + AW'(1);
                n_dst = r_src - AW'(1);
            end
        end

        // read data for a read request
        if ((r_state == plid_pkg::ST_SHIFT) && r_pend && (r_op == plid_pkg::FUNC_READ)) begin
            n_rd = r_rdata;
        end

        // length update once the memory pass is complete
        if (r_state == plid_pkg::ST_FINISH) begin
            if (r_op == plid_pkg::FUNC_INSERT) begin
                n_count = r_count + plid_pkg::CNT_W'(1);
            end else if (r_op == plid_pkg::FUNC_DELETE) begin
                n_count = r_count - plid_pkg::CNT_W'(1);
            end
        end

        // result register
        if (w_load_out) begin
            n_o_valid      = 1'b1;
            n_o_status     = r_legal ? plid_pkg::STATUS_OK : plid_pkg::STATUS_ERR;
            n_o_length     = r_count;
            n_o_read_value = r_rd;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= plid_pkg::ST_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_legal        <= n_legal;
        r_left         <= n_left;
        r_src          <= n_src;
        r_dst          <= n_dst;
        r_slot         <= n_slot;
        r_val          <= n_val;
        r_rd           <= n_rd;
        r_o_status     <= n_o_status;
        r_o_length     <= n_o_length;
        r_o_read_value <= n_o_read_value;
    end

    // ------------------------------------------------------------------
    // Entry memory: one write, one registered read per cycle. The shift
    // reads run ahead of the writes in the direction of travel, so the two
    // ports never address the same entry in one cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_src];
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_length     = r_o_length;
    assign o_read_value = r_o_read_value;

`ifndef ASSERT_OFF
    // length never exceeds the list limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plid_pkg::CNT_W'(LIMIT))
        else $error("list length above limit");

    // shift write-back never collides with the read issued alongside it
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_issue) |-> (w_waddr != r_src))
        else $error("read and write address collide during shift");

    // length changes only at the end of a legal insert or delete
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> ($past(r_state) == plid_pkg::ST_FINISH))
        else $error("length changed outside the finish step");

    // an error result carries zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == plid_pkg::STATUS_ERR)) |-> (o_read_value == '0))
        else $error("error result with non-zero data");

    // no write-back left pending once back at idle
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !r_pend)
        else $error("pending memory write while idle");
`endif

endmodule

// File: tb/positional_list_insert_delete_unit_tb.sv
// ============================================================================
// positional_list_insert_delete_unit_tb
// Self-checking bench for the positional list insert/delete unit. A short
// stimulus table covers the empty list, out-of-range and zero positions, the
// unused request code and extreme values. Random walks follow, which fill the
// list to its limit (including inserts into a full list) and drain it again.
// Untyped results are checked against a behavioural list model in this file.
// Both channels idle in phases, and the result side is held off for one long
// stretch so that the unit backs up and stalls its request channel.
// ============================================================================
module positional_list_insert_delete_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plid_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int LIST_LIMIT      = (CAPACITY < LEN_MAX) ? CAPACITY : LEN_MAX;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 500;
    localparam int FIRST_FILL      = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = CAPACITY + 16;
    localparam int DIR_ROWS        = 22;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Bias of the random walk over the list length
    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_walk_mode;

    typedef struct packed {
        logic              status;
        logic [CNT_W-1:0]  length;
        logic [DATA_W-1:0] read_value;
    } t_list_result;

    // One stimulus row; typed rows carry their own expected result
    typedef struct packed {
        logic              typed;
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        t_list_result      result;
    } t_dir_row;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic                     o_ready;
    logic [FUNC_W-1:0]        i_func       = '0;
    logic [POS_W-1:0]         i_position   = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic                     o_valid;
    logic                     i_ready      = 1'b0;
    logic                     o_status;
    logic [CNT_W-1:0]         o_length;
    logic signed [DATA_W-1:0] o_read_value;

    // Idling controls and the long hold-off
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic pressure_req   = 1'b0;
    logic hold_off       = 1'b0;

    int fail_count = 0;

    // List model state
    logic [DATA_W-1:0] list_entries [CAPACITY];
    int                list_len = 0;

    t_list_result expected_results [$];

    t_dir_row dir_table [DIR_ROWS] = '{
        // empty list: nothing is in range
        '{1'b1, FUNC_READ,   7'd1,   32'h0000_0000, '{STATUS_ERR, 7'd0, 32'h0}},
        '{1'b1, FUNC_DELETE, 7'd1,   32'h0000_0000, '{STATUS_ERR, 7'd0, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd0,   32'h1234_5678, '{STATUS_ERR, 7'd0, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd2,   32'h1234_5678, '{STATUS_ERR, 7'd0, 32'h0}},
        '{1'b1, FUNC_UNUSED, 7'd1,   32'hFFFF_FFFF, '{STATUS_ERR, 7'd0, 32'h0}},
        // short list of extreme values: head, head, tail, middle
        '{1'b1, FUNC_INSERT, 7'd1,   32'h7FFF_FFFF, '{STATUS_OK,  7'd1, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd1,   32'h8000_0000, '{STATUS_OK,  7'd2, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd3,   32'hFFFF_FFFF, '{STATUS_OK,  7'd3, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd2,   32'h0000_0000, '{STATUS_OK,  7'd4, 32'h0}},
        // contents after the shifts come from the model
        '{1'b0, FUNC_READ,   7'd1,   32'h0000_0000, '0},
        '{1'b0, FUNC_READ,   7'd2,   32'h0000_0000, '0},
        '{1'b0, FUNC_READ,   7'd3,   32'hFFFF_FFFF, '0},
        '{1'b0, FUNC_READ,   7'd4,   32'h0000_0000, '0},
        // just past the end, and the top of the position field
        '{1'b1, FUNC_READ,   7'd5,   32'h0000_0000, '{STATUS_ERR, 7'd4, 32'h0}},
        '{1'b1, FUNC_DELETE, 7'd5,   32'h0000_0000, '{STATUS_ERR, 7'd4, 32'h0}},
        '{1'b1, FUNC_READ,   7'd127, 32'h0000_0000, '{STATUS_ERR, 7'd4, 32'h0}},
        '{1'b1, FUNC_INSERT, 7'd127, 32'h5A5A_5A5A, '{STATUS_ERR, 7'd4, 32'h0}},
        // delete at the tail, then at the head
        '{1'b1, FUNC_DELETE, 7'd4,   32'hFFFF_FFFF, '{STATUS_OK,  7'd3, 32'h0}},
        '{1'b1, FUNC_DELETE, 7'd1,   32'h0000_0000, '{STATUS_OK,  7'd2, 32'h0}},
        '{1'b0, FUNC_READ,   7'd1,   32'h0000_0000, '0},
        '{1'b1, FUNC_DELETE, 7'd0,   32'h0000_0000, '{STATUS_ERR, 7'd2, 32'h0}},
        '{1'b1, FUNC_UNUSED, 7'd127, 32'hFFFF_FFFF, '{STATUS_ERR, 7'd2, 32'h0}}
    };

    positional_list_insert_delete_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_length    (o_length),
        .o_read_value(o_read_value)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the list model and return its result
    task automatic apply_list_request(input logic [FUNC_W-1:0] func,
                                      input logic [POS_W-1:0] pos,
                                      input logic [DATA_W-1:0] value,
                                      output t_list_result res);
        int p;
        int k;
        p = int'(pos);
        res.status     = STATUS_ERR;
        res.read_value = '0;
        case (func)
            FUNC_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < LIST_LIMIT) begin
                    // open a gap at the position
                    for (k = list_len; k > p - 1; k--)
                        list_entries[k] = list_entries[k - 1];
                    list_entries[p - 1] = value;
                    list_len++;
                    res.status = STATUS_OK;
                end
            end
            FUNC_DELETE: begin
                if (p >= 1 && p <= list_len) begin
                    // close the gap left by the removed entry
                    for (k = p - 1; k + 1 < list_len; k++)
                        list_entries[k] = list_entries[k + 1];
                    list_len--;
                    res.status = STATUS_OK;
                end
            end
            FUNC_READ: begin
                if (p >= 1 && p <= list_len) begin
                    res.read_value = list_entries[p - 1];
                    res.status     = STATUS_OK;
                end
            end
            default: ;
        endcase
        res.length = CNT_W'(list_len);
    endtask

    // Random request, mostly legal, shaped by the walk mode
    task automatic pick_request(input t_walk_mode walk,
                                output logic [FUNC_W-1:0] func,
                                output logic [POS_W-1:0] pos,
                                output logic [DATA_W-1:0] value);
        int r;
        int w;
        int lo;
        r = $urandom_range(99);
        w = $urandom_range(99);
        case ($urandom_range(7))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom;
        endcase
        if (r < 3) begin
            func = FUNC_UNUSED;
            pos  = POS_W'($urandom);
        end else begin
            case (walk)
                MODE_FILL:
                    func = (w < 80) ? FUNC_INSERT : (w < 90) ? FUNC_DELETE : FUNC_READ;
                MODE_DRAIN:
                    func = (w < 80) ? FUNC_DELETE : (w < 90) ? FUNC_INSERT : FUNC_READ;
                default:
                    func = (w < 40) ? FUNC_INSERT : (w < 70) ? FUNC_DELETE : FUNC_READ;
            endcase
            if (r < 12) begin
                // out of range: zero, just past the end, or anywhere above
                lo = (func == FUNC_INSERT) ? list_len + 2 : list_len + 1;
                case ($urandom_range(2))
                    0:       pos = '0;
                    1:       pos = POS_W'(lo);
                    default: pos = POS_W'($urandom_range(LEN_MAX, lo));
                endcase
            end else if (func == FUNC_INSERT) begin
                pos = POS_W'($urandom_range(list_len + 1, 1));
            end else if (list_len == 0) begin
                func = FUNC_INSERT;
                pos  = POS_W'(1);
            end else begin
                pos = POS_W'($urandom_range(list_len, 1));
            end
        end
    endtask

    // Offer one request transaction; the model runs once it is accepted
    task automatic offer_request(input logic [FUNC_W-1:0] func,
                                 input logic [POS_W-1:0] pos,
                                 input logic [DATA_W-1:0] value,
                                 input logic typed,
                                 input t_list_result typed_result);
        t_list_result predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_position <= pos;
        i_value    <= value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        apply_list_request(func, pos, value, predicted);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Result side ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long hold-off, counted here so that the request side keeps offering
    initial begin
        wait (pressure_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d length %0d read_value %0d",
                         $time, o_status, o_length, o_read_value);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_length !== want.length) begin
                    $display("%0t: length mismatch: expected %0d actual %0d",
                             $time, want.length, o_length);
                    fail_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %0d actual %0d",
                             $time, $signed(want.read_value), o_read_value);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus: reset, table, then random walks in four idling phases
    initial begin
        t_walk_mode        walk;
        int                burst_left;
        int                phase;
        int                n;
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i])
            offer_request(dir_table[i].func, dir_table[i].pos, dir_table[i].value,
                          dir_table[i].typed, dir_table[i].result);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct   = 66;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 66;
                end
                default: begin
                    send_idle_pct   = 22;
                    recv_stall_pct <= 22;
                    pressure_req   <= 1'b1;
                end
            endcase
            // each phase opens with a long fill so the list reaches its limit
            walk       = MODE_FILL;
            burst_left = FIRST_FILL;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    walk       = t_walk_mode'($urandom_range(2));
                    burst_left = $urandom_range(120, 20);
                end
                burst_left--;
                pick_request(walk, func, pos, value);
                offer_request(func, pos, value, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
